// ===== rtl/core/tac_pkg.sv =====
// ============================================================================
// tac_pkg: shared types and constants for the touch average/calibrate block
// Payload structs, configuration struct, controller states, command/status.
// ============================================================================
`default_nettype none

package tac_pkg;

    // Elaboration defaults for the top-level parameters
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    // Fixed datapath widths (set by the field widths, not by parameters)
    localparam int SUM_W    = 16;   // wrapping sample accumulators
    localparam int CNT_W    = 8;    // samples taken
    localparam int DIVR_W   = 8;    // divisor 2*sample_pairs
    localparam int DIV_STEPS = SUM_W;
    localparam int DCNT_W   = $clog2(DIV_STEPS);
    localparam int PROD_W   = 49;   // 32b signed gain x 17b signed average
    localparam int V_W      = 50;   // product plus sign-extended offset
    localparam int ORI_A_W  = 18;   // full scale minus a saturated coordinate
    localparam int ORI_P_W  = 31;   // that times a 12-bit screen dimension

    // Register map indexes
    localparam logic [2:0] REG_SAMPLE_PAIRS  = 3'd0;
    localparam logic [2:0] REG_GAIN_X        = 3'd1;
    localparam logic [2:0] REG_OFFSET_X      = 3'd2;
    localparam logic [2:0] REG_GAIN_Y        = 3'd3;
    localparam logic [2:0] REG_OFFSET_Y      = 3'd4;
    localparam logic [2:0] REG_ORIENTATION   = 3'd5;
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd6;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd7;

    // Register reset values
    localparam logic [6:0]         RST_SAMPLE_PAIRS  = 7'd1;
    localparam logic signed [31:0] RST_GAIN_X        = 32'sd6513;
    localparam logic signed [31:0] RST_OFFSET_X      = -32'sd1953869;
    localparam logic signed [31:0] RST_GAIN_Y        = -32'sd6659;
    localparam logic signed [31:0] RST_OFFSET_Y      = 32'sd18978249;
    localparam logic [1:0]         RST_ORIENTATION   = 2'd0;
    localparam logic [11:0]        RST_SCREEN_WIDTH  = 12'd320;
    localparam logic [11:0]        RST_SCREEN_HEIGHT = 12'd240;

    // Orientation codes
    localparam logic [1:0] ORIENT_LAND_DIRECT   = 2'd0;
    localparam logic [1:0] ORIENT_LAND_MIRROR   = 2'd1;
    localparam logic [1:0] ORIENT_PORT_INVERTED = 2'd2;
    localparam logic [1:0] ORIENT_PORT_DIRECT   = 2'd3;

    typedef struct packed {
        logic        pressed;
        logic [11:0] raw_x;
        logic [11:0] raw_y;
        logic        screen_relative;
    } t_in_item;

    typedef struct packed {
        logic               touch_valid;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } t_out_item;

    typedef struct packed {
        logic [6:0]         sample_pairs;
        logic signed [31:0] gain_x;
        logic signed [31:0] offset_x;
        logic signed [31:0] gain_y;
        logic signed [31:0] offset_y;
        logic [1:0]         orientation;
        logic [11:0]        screen_width;
        logic [11:0]        screen_height;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COLLECT,
        ST_DIVIDE,
        ST_MULTIPLY,
        ST_OFFSET,
        ST_SCALE,
        ST_ORIENT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic start;        // touch onset: clear sums and count, latch mode
        logic accumulate;   // add one sample
        logic div_load;     // load divider with the final sums
        logic div_step;     // one quotient bit
        logic mul;          // gain times average
        logic add_off;      // plus offset
        logic scale;        // drop fraction, saturate
        logic orient_mul;   // orientation product
        logic emit_zero;    // no-touch result into the output register
        logic emit_result;  // measurement result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic last_sample;  // current sample completes the set
        logic div_done;     // last divider step this cycle
        logic mode;         // latched screen mode
        logic out_free;     // output register can take a result this cycle
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/core/tac_regs.sv =====
// ============================================================================
// tac_regs: configuration register file
// APB-style write/read of the eight setup registers, zero wait states.
// ============================================================================
`default_nettype none

module tac_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output tac_pkg::t_cfg      o_cfg
);

    tac_pkg::t_cfg r_cfg;
    tac_pkg::t_cfg n_cfg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                tac_pkg::REG_SAMPLE_PAIRS:  n_cfg.sample_pairs  = pwdata[6:0];
                tac_pkg::REG_GAIN_X:        n_cfg.gain_x        = $signed(pwdata);
                tac_pkg::REG_OFFSET_X:      n_cfg.offset_x      = $signed(pwdata);
                tac_pkg::REG_GAIN_Y:        n_cfg.gain_y        = $signed(pwdata);
                tac_pkg::REG_OFFSET_Y:      n_cfg.offset_y      = $signed(pwdata);
                tac_pkg::REG_ORIENTATION:   n_cfg.orientation   = pwdata[1:0];
                tac_pkg::REG_SCREEN_WIDTH:  n_cfg.screen_width  = pwdata[11:0];
                tac_pkg::REG_SCREEN_HEIGHT: n_cfg.screen_height = pwdata[11:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_pairs  <= tac_pkg::RST_SAMPLE_PAIRS;
            r_cfg.gain_x        <= tac_pkg::RST_GAIN_X;
            r_cfg.offset_x      <= tac_pkg::RST_OFFSET_X;
            r_cfg.gain_y        <= tac_pkg::RST_GAIN_Y;
            r_cfg.offset_y      <= tac_pkg::RST_OFFSET_Y;
            r_cfg.orientation   <= tac_pkg::RST_ORIENTATION;
            r_cfg.screen_width  <= tac_pkg::RST_SCREEN_WIDTH;
            r_cfg.screen_height <= tac_pkg::RST_SCREEN_HEIGHT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_idx)
            tac_pkg::REG_SAMPLE_PAIRS:  prdata = {25'd0, r_cfg.sample_pairs};
            tac_pkg::REG_GAIN_X:        prdata = r_cfg.gain_x;
            tac_pkg::REG_OFFSET_X:      prdata = r_cfg.offset_x;
            tac_pkg::REG_GAIN_Y:        prdata = r_cfg.gain_y;
            tac_pkg::REG_OFFSET_Y:      prdata = r_cfg.offset_y;
            tac_pkg::REG_ORIENTATION:   prdata = {30'd0, r_cfg.orientation};
            tac_pkg::REG_SCREEN_WIDTH:  prdata = {20'd0, r_cfg.screen_width};
            tac_pkg::REG_SCREEN_HEIGHT: prdata = {20'd0, r_cfg.screen_height};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/tac_ctrl.sv =====
// ============================================================================
// tac_ctrl: measurement sequencer
// Walks collect, divide, calibrate, orient and output; drives the datapath.
// ============================================================================
`default_nettype none

module tac_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_pressed,
    output logic                  o_in_ready,
    input  wire tac_pkg::t_dp_sts i_sts,
    output tac_pkg::t_dp_cmd      o_cmd
);

    tac_pkg::t_state r_state;
    tac_pkg::t_state n_state;
    logic            fire;

    assign fire = i_in_valid & o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tac_pkg::ST_IDLE: begin
                if (fire && i_pressed) n_state = tac_pkg::ST_COLLECT;
            end
            tac_pkg::ST_COLLECT: begin
                if (fire) begin
                    if (!i_pressed)             n_state = tac_pkg::ST_IDLE;
                    else if (i_sts.last_sample) n_state = tac_pkg::ST_DIVIDE;
                end
            end
            tac_pkg::ST_DIVIDE: begin
                if (i_sts.div_done) begin
                    n_state = i_sts.mode ? tac_pkg::ST_MULTIPLY : tac_pkg::ST_FINISH;
                end
            end
            tac_pkg::ST_MULTIPLY: n_state = tac_pkg::ST_OFFSET;
            tac_pkg::ST_OFFSET:   n_state = tac_pkg::ST_SCALE;
            tac_pkg::ST_SCALE:    n_state = tac_pkg::ST_ORIENT;
            tac_pkg::ST_ORIENT:   n_state = tac_pkg::ST_FINISH;
            tac_pkg::ST_FINISH: begin
                if (i_sts.out_free) n_state = tac_pkg::ST_IDLE;
            end
            default: n_state = tac_pkg::ST_IDLE;
        endcase
    end

    // outputs; in idle and collect only a release waits, for the output slot
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            tac_pkg::ST_IDLE: begin
                o_in_ready      = i_pressed | i_sts.out_free;
                o_cmd.start     = i_in_valid & o_in_ready & i_pressed;
                o_cmd.emit_zero = i_in_valid & o_in_ready & ~i_pressed;
            end
            tac_pkg::ST_COLLECT: begin
                o_in_ready       = i_pressed | i_sts.out_free;
                o_cmd.accumulate = i_in_valid & o_in_ready & i_pressed;
                o_cmd.div_load   = i_in_valid & o_in_ready & i_pressed & i_sts.last_sample;
                o_cmd.emit_zero  = i_in_valid & o_in_ready & ~i_pressed;
            end
            tac_pkg::ST_DIVIDE:   o_cmd.div_step    = 1'b1;
            tac_pkg::ST_MULTIPLY: o_cmd.mul         = 1'b1;
            tac_pkg::ST_OFFSET:   o_cmd.add_off     = 1'b1;
            tac_pkg::ST_SCALE:    o_cmd.scale       = 1'b1;
            tac_pkg::ST_ORIENT:   o_cmd.orient_mul  = 1'b1;
            tac_pkg::ST_FINISH:   o_cmd.emit_result = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tac_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tac_dp.sv =====
// ============================================================================
// tac_dp: accumulate, divide, calibrate and orient datapath
// Sample sums, bit-serial divider, Q-format calibration, output register.
// ============================================================================
`default_nettype none

module tac_dp #(
    parameter int COORD_BITS = tac_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tac_pkg::FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tac_pkg::t_cfg     i_cfg,
    input  wire logic [11:0]       i_raw_x,
    input  wire logic [11:0]       i_raw_y,
    input  wire logic              i_screen_relative,
    input  wire tac_pkg::t_dp_cmd  i_cmd,
    output tac_pkg::t_dp_sts       o_sts,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output tac_pkg::t_out_item     o_out
);

    localparam int SUM_W   = tac_pkg::SUM_W;
    localparam int CNT_W   = tac_pkg::CNT_W;
    localparam int DIVR_W  = tac_pkg::DIVR_W;
    localparam int DCNT_W  = tac_pkg::DCNT_W;
    localparam int PROD_W  = tac_pkg::PROD_W;
    localparam int V_W     = tac_pkg::V_W;
    localparam int A_W     = tac_pkg::ORI_A_W;
    localparam int P_W     = tac_pkg::ORI_P_W;

    localparam logic signed [V_W-1:0] FRAC_MASK = (V_W'(1) << FRAC_BITS) - V_W'(1);
    localparam logic signed [P_W-1:0] COORD_MASK = (P_W'(1) << COORD_BITS) - P_W'(1);
    localparam logic signed [A_W-1:0] FULL_SCALE = A_W'(1) << COORD_BITS;
    localparam logic signed [V_W-1:0] SAT_MAX = V_W'(32767);
    localparam logic signed [V_W-1:0] SAT_MIN = -V_W'(32768);

    // drop the fraction toward zero, clamp to int16
    function automatic logic signed [15:0] f_scale(input logic signed [V_W-1:0] v);
        logic signed [V_W-1:0] biased;
        logic signed [V_W-1:0] q;
        biased = v + (v[V_W-1] ? FRAC_MASK : V_W'(0));
        q      = biased >>> FRAC_BITS;
        if (q > SAT_MAX)      f_scale = 16'sh7FFF;
        else if (q < SAT_MIN) f_scale = 16'sh8000;
        else                  f_scale = q[15:0];
    endfunction

    // divide by the coordinate full scale toward zero, wrap to 16 bits
    function automatic logic signed [15:0] f_unscale(input logic signed [P_W-1:0] p);
        logic signed [P_W-1:0] biased;
        logic signed [P_W-1:0] q;
        biased    = p + (p[P_W-1] ? COORD_MASK : P_W'(0));
        q         = biased >>> COORD_BITS;
        f_unscale = q[15:0];
    endfunction

    // measurement state
    logic [CNT_W-1:0]  r_cnt;
    logic [SUM_W-1:0]  r_sum_x, r_sum_y;
    logic              r_mode;
    logic [SUM_W-1:0]  n_sum_x, n_sum_y;

    // divider
    logic [SUM_W-1:0]  r_quo_x, r_quo_y;
    logic [DIVR_W-1:0] r_rem_x, r_rem_y;
    logic [DCNT_W-1:0] r_dcnt;
    logic [DIVR_W-1:0] divisor;
    logic [6:0]        pairs_eff;
    logic [DIVR_W:0]   rsh_x, rsh_y;
    logic              ge_x, ge_y;

    // calibration and orientation
    logic signed [PROD_W-1:0] r_prod_x, r_prod_y;
    logic signed [V_W-1:0]    r_v_x, r_v_y;
    logic signed [15:0]       r_c_x, r_c_y;
    logic signed [P_W-1:0]    r_op_x, r_op_y;
    logic signed [A_W-1:0]    ora_x, ora_y;
    logic signed [15:0]       res_x, res_y;

    // output register
    logic                 r_out_valid;
    tac_pkg::t_out_item   r_out;

    assign pairs_eff = (i_cfg.sample_pairs == 7'd0) ? 7'd1 : i_cfg.sample_pairs;
    assign divisor   = {pairs_eff, 1'b0};
    assign n_sum_x   = r_sum_x + SUM_W'(i_raw_x);
    assign n_sum_y   = r_sum_y + SUM_W'(i_raw_y);

    assign rsh_x = {r_rem_x, r_quo_x[SUM_W-1]};
    assign rsh_y = {r_rem_y, r_quo_y[SUM_W-1]};
    assign ge_x  = rsh_x >= {1'b0, divisor};
    assign ge_y  = rsh_y >= {1'b0, divisor};

    assign o_sts.last_sample = ({1'b0, r_cnt} + (CNT_W+1)'(1)) >= (CNT_W+1)'(divisor);
    assign o_sts.div_done    = r_dcnt == DCNT_W'(tac_pkg::DIV_STEPS - 1);
    assign o_sts.mode        = r_mode;
    assign o_sts.out_free    = ~r_out_valid | i_out_ready;

    // orientation operands: swapped axes, inverted for portrait inverted
    always_comb begin
        if (i_cfg.orientation == tac_pkg::ORIENT_PORT_INVERTED) begin
            ora_x = FULL_SCALE - A_W'(r_c_y);
            ora_y = FULL_SCALE - A_W'(r_c_x);
        end else begin
            ora_x = A_W'(r_c_y);
            ora_y = A_W'(r_c_x);
        end
    end

    always_comb begin
        res_x = r_quo_x;
        res_y = r_quo_y;
        if (r_mode) begin
            case (i_cfg.orientation)
                tac_pkg::ORIENT_LAND_DIRECT: begin
                    res_x = r_c_x;
                    res_y = r_c_y;
                end
                tac_pkg::ORIENT_LAND_MIRROR: begin
                    res_x = $signed(16'(i_cfg.screen_width)) - r_c_x;
                    res_y = $signed(16'(i_cfg.screen_height)) - r_c_y;
                end
                tac_pkg::ORIENT_PORT_INVERTED,
                tac_pkg::ORIENT_PORT_DIRECT: begin
                    res_x = f_unscale(r_op_x);
                    res_y = f_unscale(r_op_y);
                end
                default: begin
                    res_x = r_c_x;
                    res_y = r_c_y;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_mode  <= 1'b0;
            r_dcnt  <= '0;
        end else begin
            if (i_cmd.start) begin
                r_cnt   <= '0;
                r_sum_x <= '0;
                r_sum_y <= '0;
                r_mode  <= i_screen_relative;
            end else if (i_cmd.accumulate) begin
                r_sum_x <= n_sum_x;
                r_sum_y <= n_sum_y;
                r_cnt   <= i_cmd.div_load ? '0 : r_cnt + CNT_W'(1);
            end
            if (i_cmd.div_load) begin
                r_dcnt <= '0;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
        end
    end

    // payload path, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_quo_x <= n_sum_x;
            r_quo_y <= n_sum_y;
            r_rem_x <= '0;
            r_rem_y <= '0;
        end else if (i_cmd.div_step) begin
            r_quo_x <= {r_quo_x[SUM_W-2:0], ge_x};
            r_quo_y <= {r_quo_y[SUM_W-2:0], ge_y};
            r_rem_x <= ge_x ? DIVR_W'(rsh_x - {1'b0, divisor}) : DIVR_W'(rsh_x);
            r_rem_y <= ge_y ? DIVR_W'(rsh_y - {1'b0, divisor}) : DIVR_W'(rsh_y);
        end
        if (i_cmd.mul) begin
            r_prod_x <= i_cfg.gain_x * $signed({1'b0, r_quo_x});
            r_prod_y <= i_cfg.gain_y * $signed({1'b0, r_quo_y});
        end
        if (i_cmd.add_off) begin
            r_v_x <= V_W'(r_prod_x) + V_W'(i_cfg.offset_x);
            r_v_y <= V_W'(r_prod_y) + V_W'(i_cfg.offset_y);
        end
        if (i_cmd.scale) begin
            r_c_x <= f_scale(r_v_x);
            r_c_y <= f_scale(r_v_y);
        end
        if (i_cmd.orient_mul) begin
            r_op_x <= ora_x * $signed({1'b0, i_cfg.screen_width});
            r_op_y <= ora_y * $signed({1'b0, i_cfg.screen_height});
        end
        if (i_cmd.emit_zero) begin
            r_out <= '0;
        end else if (i_cmd.emit_result) begin
            r_out.touch_valid <= 1'b1;
            r_out.pos_x       <= res_x;
            r_out.pos_y       <= res_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_zero || i_cmd.emit_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/touch_average_calibrate_top.sv =====
// ============================================================================
// touch_average_calibrate_top: touch sample averaging and screen calibration
// Averages touch-controller samples and maps them to raw or screen coordinates.
// ============================================================================
// Usage: feed one controller sample per input transfer. Idle and untouched
// gives an immediate no-touch result (zero coordinates). A touched sample
// opens a measurement (it is dropped, no result) and latches screen_relative;
// the next 2*sample_pairs touched samples are summed in 16-bit wrapping sums
// and a release on the way gives a no-touch result. Touched samples during
// collection are never held off; a release is held off only while the output
// register is full and not being drained. At the end a bit-serial divider
// produces both averages, then screen mode goes on through gain multiply,
// offset add, fraction drop/saturate and orientation multiply; no new sample
// is taken from the last sample until its result enters the output register.
// Config registers sit at byte address 4*index on the APB port, zero wait
// states, and are meant to be changed only while no measurement runs.
// ============================================================================
`default_nettype none

module touch_average_calibrate_top #(
    parameter int COORD_BITS = tac_pkg::COORD_BITS_DEF,  // orientation full scale 2^n
    parameter int FRAC_BITS  = tac_pkg::FRAC_BITS_DEF    // calibration fraction bits
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // sample input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire tac_pkg::t_in_item  i_in,
    // result output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output tac_pkg::t_out_item      o_out,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    tac_pkg::t_cfg    cfg;
    tac_pkg::t_dp_cmd cmd;
    tac_pkg::t_dp_sts sts;

    // setup registers
    tac_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer: owns input ready, steps the datapath
    tac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_pressed  (i_in.pressed),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // sums, divider, calibration, orientation, output register
    tac_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_raw_x           (i_in.raw_x),
        .i_raw_y           (i_in.raw_y),
        .i_screen_relative (i_in.screen_relative),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out             (o_out)
    );

endmodule

`default_nettype wire

// ===== rtl/core/tac_checker.sv =====
// ============================================================================
// tac_checker: port-level checks for the touch average/calibrate block
// Output hold, no-touch zeros, and release-to-result timing.
// ============================================================================
`default_nettype none

module tac_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire tac_pkg::t_in_item  i_in,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire tac_pkg::t_out_item o_out
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // no-touch results carry zero coordinates
    a_zero_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.touch_valid |-> o_out.pos_x == 16'sd0 && o_out.pos_y == 16'sd0)
        else $error("no-touch result with nonzero coordinates");

    // an untouched sample transfer is answered at once with a no-touch result
    a_release_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_in.pressed |=> o_out_valid && !o_out.touch_valid)
        else $error("untouched sample not answered next cycle");

endmodule

bind touch_average_calibrate_top tac_checker u_tac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire
